@@ rtl/dawm_pkg.sv @@
// Shared types, constants and arithmetic step functions of the wedge merge pipeline.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package dawm_pkg;

  localparam int unsigned ROOT_STEPS   = 32;
  localparam int unsigned SLOPE_STEPS  = 28;
  localparam int unsigned WEIGHT_STEPS = 17;
  localparam logic [16:0] HALF_WEIGHT  = 17'd32768;

  typedef enum logic [2:0] {
    REG_SWAP_AXES,
    REG_RADIUS_WEIGHTING,
    REG_TAN_A_LOW,
    REG_TAN_A_HIGH,
    REG_TAN_B_LOW,
    REG_TAN_B_HIGH,
    REG_INV_X_ASPECT,
    REG_INV_Y_ASPECT
  } dawm_reg_e;

  typedef struct packed {
    logic [11:0]        column;
    logic signed [11:0] row_offset;
    logic signed [11:0] slice_offset;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } dawm_in_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic               inside_a;
    logic               inside_b;
  } dawm_out_t;

  typedef struct packed {
    logic               swap_axes;
    logic               radius_weighting;
    logic signed [31:0] tan_a_low;
    logic signed [31:0] tan_a_high;
    logic signed [31:0] tan_b_low;
    logic signed [31:0] tan_b_high;
    logic [31:0]        inv_x_aspect;
    logic [31:0]        inv_y_aspect;
  } dawm_cfg_t;

  localparam dawm_cfg_t CFG_RESET = '{
    swap_axes:        1'b1,
    radius_weighting: 1'b0,
    tan_a_low:        -32'sd113512,
    tan_a_high:       32'sd113512,
    tan_b_low:        -32'sd113512,
    tan_b_high:       32'sd113512,
    inv_x_aspect:     32'd65536,
    inv_y_aspect:     32'd65536
  };

  typedef struct packed {
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } dawm_smp_t;

  typedef struct packed {
    dawm_smp_t          smp;
    logic signed [11:0] z;
    logic [27:0]        x;
    logic [27:0]        ymag;
    logic               ysign;
    logic [63:0]        rad_x;
    logic [63:0]        rad_y;
  } dawm_front_t;

  typedef struct packed {
    dawm_smp_t          smp;
    logic signed [11:0] z;
    logic [27:0]        x;
    logic [27:0]        ymag;
    logic               ysign;
    logic [63:0]        vx;
    logic [63:0]        vy;
    logic [33:0]        rem_x;
    logic [33:0]        rem_y;
    logic [31:0]        root_x;
    logic [31:0]        root_y;
    logic [27:0]        num;
    logic [33:0]        dr_x;
    logic [33:0]        dr_y;
    logic [27:0]        q_x;
    logic [27:0]        q_y;
  } dawm_root_t;

  typedef struct packed {
    dawm_smp_t   smp;
    logic        ina;
    logic        inb;
    logic        zero;
    logic [32:0] rsum;
    logic [33:0] rem1;
    logic [33:0] rem2;
    logic [16:0] q1;
    logic [16:0] q2;
    logic        lsb1;
    logic        lsb2;
  } dawm_wgt_t;

  // one restoring divide step: {quotient bit, remainder}
  function automatic logic [34:0] div_step(input logic [33:0] rem, input logic [32:0] den,
                                           input logic b);
    logic [34:0] sh;
    logic [34:0] res;
    sh = {rem, b};
    if (sh >= {2'b00, den}) begin
      res = {1'b1, 34'(sh - {2'b00, den})};
    end else begin
      res = {1'b0, sh[33:0]};
    end
    return res;
  endfunction

  // one digit of the integer square root: {root, remainder}
  function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] bits);
    logic [35:0] r;
    logic [35:0] t;
    logic [65:0] res;
    r = {rem, bits};
    t = {2'b00, root, 2'b01};
    if (r >= t) begin
      res = {root[30:0], 1'b1, 34'(r - t)};
    end else begin
      res = {root[30:0], 1'b0, r[33:0]};
    end
    return res;
  endfunction

  function automatic dawm_root_t root_stage(input dawm_root_t s, input int unsigned k);
    logic [65:0] sx;
    logic [65:0] sy;
    logic [34:0] dx;
    logic [34:0] dy;
    dawm_root_t  r;
    r = s;
    sx = sqrt_step(s.rem_x, s.root_x, s.vx[63:62]);
    sy = sqrt_step(s.rem_y, s.root_y, s.vy[63:62]);
    r.root_x = sx[65:34];
    r.rem_x  = sx[33:0];
    r.root_y = sy[65:34];
    r.rem_y  = sy[33:0];
    r.vx     = {s.vx[61:0], 2'b00};
    r.vy     = {s.vy[61:0], 2'b00};
    if (k < SLOPE_STEPS) begin
      dx = div_step(s.dr_x, {5'b0, s.x}, s.num[27]);
      dy = div_step(s.dr_y, {5'b0, s.ymag}, s.num[27]);
      r.dr_x = dx[33:0];
      r.dr_y = dy[33:0];
      r.q_x  = {s.q_x[26:0], dx[34]};
      r.q_y  = {s.q_y[26:0], dy[34]};
      r.num  = {s.num[26:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dawm_wgt_t wgt_stage(input dawm_wgt_t s, input int unsigned k);
    logic [34:0] d1;
    logic [34:0] d2;
    dawm_wgt_t   r;
    r = s;
    d1 = div_step(s.rem1, s.rsum, (k == 0) ? s.lsb1 : 1'b0);
    d2 = div_step(s.rem2, s.rsum, (k == 0) ? s.lsb2 : 1'b0);
    r.rem1 = d1[33:0];
    r.rem2 = d2[33:0];
    r.q1   = {s.q1[15:0], d1[34]};
    r.q2   = {s.q2[15:0], d2[34]};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dawm_front.sv @@
// Front stages: axis select, aspect scaling, squares and radicands.
// Depends on dawm_pkg.
`default_nettype none
module dawm_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  dawm_pkg::dawm_cfg_t    cfg_i,
  input  wire                    in_valid_i,
  input  dawm_pkg::dawm_in_t     in_word_i,
  output logic                   out_vld_o,
  output dawm_pkg::dawm_front_t  out_o
);
  import dawm_pkg::*;

  logic               p1_vld_q;
  dawm_in_t           p1_q;
  logic               p2_vld_q;
  dawm_smp_t          p2_smp_q;
  logic signed [11:0] p2_z_q;
  logic [43:0]        p2_px_q;
  logic [43:0]        p2_py_q;
  logic               p2_ysign_q;
  logic               p3_vld_q;
  dawm_front_t        p3_q;

  logic signed [11:0] z1;
  logic signed [11:0] yc1;
  logic [11:0]        ycmag1;
  logic [43:0]        px_d;
  logic [43:0]        py_d;
  dawm_smp_t          smp1;
  logic [27:0]        x2;
  logic [27:0]        ym2;
  logic [11:0]        zmag2;
  logic [55:0]        xx2;
  logic [55:0]        yy2;
  logic [23:0]        zz2;
  dawm_front_t        p3_d;

  always_comb begin
    z1     = cfg_i.swap_axes ? p1_q.row_offset : p1_q.slice_offset;
    yc1    = cfg_i.swap_axes ? p1_q.slice_offset : p1_q.row_offset;
    ycmag1 = yc1[11] ? 12'(-yc1) : 12'(yc1);
    px_d   = 44'(p1_q.column) * 44'(cfg_i.inv_x_aspect);
    py_d   = 44'(ycmag1) * 44'(cfg_i.inv_y_aspect);
    smp1   = '{a_real: p1_q.a_real, a_imag: p1_q.a_imag,
               b_real: p1_q.b_real, b_imag: p1_q.b_imag};
  end

  always_comb begin
    x2    = p2_px_q[43:16];
    ym2   = p2_py_q[43:16];
    zmag2 = p2_z_q[11] ? 12'(-p2_z_q) : 12'(p2_z_q);
    xx2   = 56'(x2) * 56'(x2);
    yy2   = 56'(ym2) * 56'(ym2);
    zz2   = 24'(zmag2) * 24'(zmag2);
    p3_d.smp   = p2_smp_q;
    p3_d.z     = p2_z_q;
    p3_d.x     = x2;
    p3_d.ymag  = ym2;
    p3_d.ysign = p2_ysign_q;
    p3_d.rad_x = {58'(xx2) + 58'(zz2), 6'b0};
    p3_d.rad_y = {58'(yy2) + 58'(zz2), 6'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (en_i) begin
      p1_vld_q <= in_valid_i;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q       <= in_word_i;
      p2_smp_q   <= smp1;
      p2_z_q     <= z1;
      p2_px_q    <= px_d;
      p2_py_q    <= py_d;
      p2_ysign_q <= yc1[11];
      p3_q       <= p3_d;
    end
  end

  assign out_vld_o = p3_vld_q;
  assign out_o     = p3_q;

endmodule
`default_nettype wire

@@ rtl/dawm_root.sv @@
// Radius square roots and slope quotients, one digit per pipeline stage.
// Depends on dawm_pkg.
`default_nettype none
module dawm_root (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    in_vld_i,
  input  dawm_pkg::dawm_front_t  in_i,
  output logic                   out_vld_o,
  output dawm_pkg::dawm_root_t   out_o
);
  import dawm_pkg::*;

  dawm_root_t entry;
  logic [11:0] zmag;
  logic       vld_q   [ROOT_STEPS];
  dawm_root_t stage_q [ROOT_STEPS];
  dawm_root_t stage_d [ROOT_STEPS];

  always_comb begin
    zmag         = in_i.z[11] ? 12'(-in_i.z) : 12'(in_i.z);
    entry.smp    = in_i.smp;
    entry.z      = in_i.z;
    entry.x      = in_i.x;
    entry.ymag   = in_i.ymag;
    entry.ysign  = in_i.ysign;
    entry.vx     = in_i.rad_x;
    entry.vy     = in_i.rad_y;
    entry.rem_x  = '0;
    entry.rem_y  = '0;
    entry.root_x = '0;
    entry.root_y = '0;
    entry.num    = {zmag, 16'b0};
    entry.dr_x   = '0;
    entry.dr_y   = '0;
    entry.q_x    = '0;
    entry.q_y    = '0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign stage_d[k] = root_stage(entry, k);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= in_vld_i;
        end
      end
    end else begin : g_body
      assign stage_d[k] = root_stage(stage_q[k-1], k);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign out_vld_o = vld_q[ROOT_STEPS-1];
  assign out_o     = stage_q[ROOT_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/dawm_weight.sv @@
// Slope window tests and radius weight quotients, one quotient bit per stage.
// Depends on dawm_pkg.
`default_nettype none
module dawm_weight (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  dawm_pkg::dawm_cfg_t   cfg_i,
  input  wire                   in_vld_i,
  input  dawm_pkg::dawm_root_t  in_i,
  output logic                  out_vld_o,
  output dawm_pkg::dawm_wgt_t   out_o
);
  import dawm_pkg::*;

  logic signed [31:0] zox;
  logic signed [31:0] zoy;
  logic signed [33:0] zox_w;
  logic signed [33:0] neg_al;
  logic signed [33:0] neg_ah;
  logic [32:0]        rsum;
  dawm_wgt_t          head_d;
  logic               head_vld_q;
  dawm_wgt_t          head_q;
  logic               vld_q   [WEIGHT_STEPS];
  dawm_wgt_t          stage_q [WEIGHT_STEPS];
  dawm_wgt_t          stage_d [WEIGHT_STEPS];

  always_comb begin
    if (in_i.x == '0) begin
      zox = (in_i.z > 12'sd0) ? 32'sh7FFFFFFF : 32'sh80000000;
    end else begin
      zox = in_i.z[11] ? -$signed({4'b0, in_i.q_x}) : $signed({4'b0, in_i.q_x});
    end
    if (in_i.ymag == '0) begin
      zoy = (in_i.z > 12'sd0) ? 32'sh7FFFFFFF : 32'sh80000000;
    end else begin
      zoy = (in_i.z[11] ^ in_i.ysign) ? -$signed({4'b0, in_i.q_y})
                                      : $signed({4'b0, in_i.q_y});
    end
    zox_w  = 34'(zox);
    neg_al = -34'(cfg_i.tan_a_low);
    neg_ah = -34'(cfg_i.tan_a_high);
    rsum   = {1'b0, in_i.root_x} + {1'b0, in_i.root_y};
    head_d.smp  = in_i.smp;
    head_d.ina  = !((zox_w > neg_al) || (zox_w < neg_ah));
    head_d.inb  = !((zoy < cfg_i.tan_b_low) || (zoy > cfg_i.tan_b_high));
    head_d.zero = (rsum == '0);
    head_d.rsum = rsum;
    head_d.rem1 = 34'(in_i.root_y[31:1]);
    head_d.rem2 = 34'(in_i.root_x[31:1]);
    head_d.lsb1 = in_i.root_y[0];
    head_d.lsb2 = in_i.root_x[0];
    head_d.q1   = '0;
    head_d.q2   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
    end else if (en_i) begin
      head_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      head_q <= head_d;
    end
  end

  for (genvar k = 0; k < WEIGHT_STEPS; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign stage_d[k] = wgt_stage(head_q, k);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= head_vld_q;
        end
      end
    end else begin : g_body
      assign stage_d[k] = wgt_stage(stage_q[k-1], k);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign out_vld_o = vld_q[WEIGHT_STEPS-1];
  assign out_o     = stage_q[WEIGHT_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/dawm_merge.sv @@
// Weighted sum of both samples or the lone one inside its wedge, rounding,
// saturation and output register. Depends on dawm_pkg.
`default_nettype none
module dawm_merge (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  dawm_pkg::dawm_cfg_t  cfg_i,
  input  wire                  in_vld_i,
  input  dawm_pkg::dawm_wgt_t  in_i,
  output logic                 out_valid_o,
  output dawm_pkg::dawm_out_t  out_word_o
);
  import dawm_pkg::*;

  function automatic logic signed [31:0] scale_sat(input logic signed [50:0] v);
    logic signed [50:0] t;
    logic signed [31:0] res;
    t = v[50] ? ((v + 51'sd65535) >>> 16) : (v >>> 16);
    if (t > 51'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (t < -51'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = t[31:0];
    end
    return res;
  endfunction

  logic [16:0]        s1;
  logic [16:0]        s2;
  logic               m1_vld_q;
  dawm_smp_t          m1_smp_q;
  logic               m1_ina_q;
  logic               m1_inb_q;
  logic signed [49:0] m1_ar_q;
  logic signed [49:0] m1_ai_q;
  logic signed [49:0] m1_br_q;
  logic signed [49:0] m1_bi_q;
  logic signed [49:0] ar_d;
  logic signed [49:0] ai_d;
  logic signed [49:0] br_d;
  logic signed [49:0] bi_d;
  dawm_out_t          out_d;
  logic               out_vld_q;
  dawm_out_t          out_q;

  always_comb begin
    s1   = (cfg_i.radius_weighting && !in_i.zero) ? in_i.q1 : HALF_WEIGHT;
    s2   = (cfg_i.radius_weighting && !in_i.zero) ? in_i.q2 : HALF_WEIGHT;
    ar_d = in_i.smp.a_real * $signed({1'b0, s1});
    ai_d = in_i.smp.a_imag * $signed({1'b0, s1});
    br_d = in_i.smp.b_real * $signed({1'b0, s2});
    bi_d = in_i.smp.b_imag * $signed({1'b0, s2});
  end

  always_comb begin
    out_d.inside_a = m1_ina_q;
    out_d.inside_b = m1_inb_q;
    if (!m1_ina_q && m1_inb_q) begin
      out_d.out_real = m1_smp_q.b_real;
      out_d.out_imag = m1_smp_q.b_imag;
    end else if (m1_ina_q && !m1_inb_q) begin
      out_d.out_real = m1_smp_q.a_real;
      out_d.out_imag = m1_smp_q.a_imag;
    end else begin
      out_d.out_real = scale_sat(51'(m1_ar_q) + 51'(m1_br_q));
      out_d.out_imag = scale_sat(51'(m1_ai_q) + 51'(m1_bi_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      m1_vld_q  <= in_vld_i;
      out_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_smp_q <= in_i.smp;
      m1_ina_q <= in_i.ina;
      m1_inb_q <= in_i.inb;
      m1_ar_q  <= ar_d;
      m1_ai_q  <= ai_d;
      m1_br_q  <= br_d;
      m1_bi_q  <= bi_d;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/dual_axis_fourier_wedge_merge_top.sv @@
// Dual-axis Fourier wedge merge: the voxel stream goes in, merged samples come out.
// Input word: voxel coordinates and the A and B samples; output word: merged sample
// and the two wedge flags. Configuration goes through a plain indexed write port.
// The 32 square root digit stages and the 17 weight quotient stages lie in series
// with the scaling and product stages.
// Throughput: one word per cycle while the output word is taken; every stage
// holds a valid bit beside its data.
// Stall: when the output word is not taken, the whole pipeline holds and in_ready_o
// drops; nothing is lost or repeated.
// Reset: clears all valid bits and loads the register defaults (row offset as z,
// equal halves, +-60 degree windows, unit aspects).
// Write configuration only while no word is in flight.
// Depends on dawm_pkg, dawm_front, dawm_root, dawm_weight, dawm_merge.
`default_nettype none
module dual_axis_fourier_wedge_merge_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dawm_pkg::dawm_in_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output dawm_pkg::dawm_out_t  out_word_o,
  input  wire                  cfg_we_i,
  input  wire [2:0]            cfg_idx_i,
  input  wire [31:0]           cfg_data_i
);
  import dawm_pkg::*;

  dawm_cfg_t   cfg_q;
  logic        en;
  logic        f_vld;
  dawm_front_t f_st;
  logic        r_vld;
  dawm_root_t  r_st;
  logic        w_vld;
  dawm_wgt_t   w_st;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (dawm_reg_e'(cfg_idx_i))
        REG_SWAP_AXES:        cfg_q.swap_axes        <= cfg_data_i[0];
        REG_RADIUS_WEIGHTING: cfg_q.radius_weighting <= cfg_data_i[0];
        REG_TAN_A_LOW:        cfg_q.tan_a_low        <= cfg_data_i;
        REG_TAN_A_HIGH:       cfg_q.tan_a_high       <= cfg_data_i;
        REG_TAN_B_LOW:        cfg_q.tan_b_low        <= cfg_data_i;
        REG_TAN_B_HIGH:       cfg_q.tan_b_high       <= cfg_data_i;
        REG_INV_X_ASPECT:     cfg_q.inv_x_aspect     <= cfg_data_i;
        REG_INV_Y_ASPECT:     cfg_q.inv_y_aspect     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dawm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .out_vld_o  (f_vld),
    .out_o      (f_st)
  );

  dawm_root u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (f_vld),
    .in_i      (f_st),
    .out_vld_o (r_vld),
    .out_o     (r_st)
  );

  dawm_weight u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .in_vld_i  (r_vld),
    .in_i      (r_st),
    .out_vld_o (w_vld),
    .out_o     (w_st)
  );

  dawm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .in_vld_i    (w_vld),
    .in_i        (w_st),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTH
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(f_st) && $stable(f_vld))
    else $error("front stage moved during stall");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_vld && !w_st.zero) |->
      ((18'(w_st.q1) + 18'(w_st.q2)) == 18'd65536) ||
      ((18'(w_st.q1) + 18'(w_st.q2)) == 18'd65535))
    else $error("radius weights do not sum to one");
`endif

endmodule
`default_nettype wire
